### hw/rtl/ili_pkg.sv
// ----------------------------------------------------------------------------
// ili_pkg
// Operation and status codes and the per-cycle command shared by the list
// cells and the top level.
// ----------------------------------------------------------------------------
package ili_pkg;

  localparam logic [1:0] OP_INSERT      = 2'd0;
  localparam logic [1:0] OP_APPEND      = 2'd1;
  localparam logic [1:0] OP_DELETE_AT   = 2'd2;
  localparam logic [1:0] OP_DELETE_LAST = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  // Shift command broadcast to every cell for one cycle
  typedef struct packed {
    logic ins;
    logic del;
  } ili_cmd_t;

endpackage

### hw/rtl/ili_cell.sv
// ----------------------------------------------------------------------------
// ili_cell
// One list entry. Loads the new value, takes its lower neighbor on insert or
// its upper neighbor on delete, and offers its old value when it is the one
// being removed.
// ----------------------------------------------------------------------------
module ili_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 7
) (
  input  logic                         clk,
  input  ili_pkg::ili_cmd_t            cmd,
  input  logic [IDX_W-1:0]             idx,
  input  logic [ili_pkg::DATA_W-1:0]   value,
  input  logic [ili_pkg::DATA_W-1:0]   lower_data,
  input  logic [ili_pkg::DATA_W-1:0]   upper_data,
  output logic [ili_pkg::DATA_W-1:0]   data,
  output logic [ili_pkg::DATA_W-1:0]   pick
);

  logic at_idx;
  logic above_idx;

  assign at_idx    = (idx == IDX_W'(INDEX));
  assign above_idx = (IDX_W'(INDEX) > idx);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (above_idx) begin
        data <= lower_data;
      end else if (at_idx) begin
        data <= value;
      end
    end else if (cmd.del) begin
      if (above_idx || at_idx) begin
        data <= upper_data;
      end
    end
  end

  assign pick = (cmd.del && at_idx) ? data : '0;

endmodule

### hw/rtl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Fixed-capacity packed list of signed words with insert, append, delete at
// index and delete last.
// ----------------------------------------------------------------------------
// The list is a row of LIST_CAPACITY register cells; every cell shifts toward
// or away from its neighbor in the cycle a request is taken, so the list state
// is updated at the accepting edge and a request can be taken every cycle
// unless the output stalls. Each result passes an accept register, then the
// output registers; a delete's removed value is gathered through a two-level
// registered OR tree (groups of eight cells, then the groups). Refused requests
// change nothing and report full, index beyond length or empty. Entries are
// not cleared on reset; only entries below the count are ever read.
module indexed_list_insert_delete #(
  parameter int LIST_CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic signed [ili_pkg::DATA_W-1:0] value,
  input  logic [ili_pkg::POS_W-1:0]     position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic signed [ili_pkg::DATA_W-1:0] removed_value,
  output logic [ili_pkg::COUNT_W-1:0]   count_now,
  output logic                          is_empty,
  output logic                          is_full
);

  localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);
  localparam int IDX_W  = (CNT_W > ili_pkg::POS_W) ? CNT_W : ili_pkg::POS_W;
  localparam int OUT_W  = (CNT_W > ili_pkg::COUNT_W) ? CNT_W : ili_pkg::COUNT_W;
  localparam int GROUP  = 8;
  localparam int GROUPS = (LIST_CAPACITY + GROUP - 1) / GROUP;
  localparam int DW     = ili_pkg::DATA_W;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  count_ext;
  logic [IDX_W-1:0]  pos_ext;
  logic [IDX_W-1:0]  idx;
  logic [1:0]        st;
  ili_pkg::ili_cmd_t cmd;
  logic              accept;
  logic              is_ins_op;
  logic              list_full;

  logic [DW-1:0] cell_data [LIST_CAPACITY];
  logic [DW-1:0] cell_pick [LIST_CAPACITY];
  logic [DW-1:0] group_or  [GROUPS];
  logic [DW-1:0] group_reg [GROUPS];
  logic [DW-1:0] removed_or;

  logic             a_valid;
  logic [1:0]       a_status;
  logic             a_del;
  logic [CNT_W-1:0] a_count;
  logic             a_move;
  logic [OUT_W-1:0] a_count_ext;

  assign a_move   = a_valid && !(out_valid && out_stall);
  assign in_stall = a_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign count_ext = IDX_W'(count);
  assign pos_ext   = IDX_W'(position);
  assign is_ins_op = (operation == ili_pkg::OP_INSERT) || (operation == ili_pkg::OP_APPEND);
  assign list_full = (count == CNT_W'(LIST_CAPACITY));

  // Decide status, target index and the shift for this request
  always_comb begin
    st         = ili_pkg::ST_DONE;
    idx        = pos_ext;
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    count_next = count;
    if (is_ins_op) begin
      if (list_full) begin
        st = ili_pkg::ST_FULL;
      end else if (operation == ili_pkg::OP_INSERT && pos_ext > count_ext) begin
        st = ili_pkg::ST_RANGE;
      end else begin
        if (operation == ili_pkg::OP_APPEND) begin
          idx = count_ext;
        end
        cmd.ins    = 1'b1;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (count == '0) begin
        st = ili_pkg::ST_EMPTY;
      end else if (operation == ili_pkg::OP_DELETE_AT && pos_ext >= count_ext) begin
        st = ili_pkg::ST_RANGE;
      end else begin
        if (operation == ili_pkg::OP_DELETE_LAST) begin
          idx = count_ext - IDX_W'(1);
        end
        cmd.del    = 1'b1;
        count_next = count - CNT_W'(1);
      end
    end
    if (!accept) begin
      cmd.ins    = 1'b0;
      cmd.del    = 1'b0;
      count_next = count;
    end
  end

  for (genvar i = 0; i < LIST_CAPACITY; i++) begin : g_cell
    logic [DW-1:0] lower;
    logic [DW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == LIST_CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    ili_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idx),
      .value      (value),
      .lower_data (lower),
      .upper_data (upper),
      .data       (cell_data[i]),
      .pick       (cell_pick[i])
    );
  end

  // First tree level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < LIST_CAPACITY) begin
          group_or[g] = group_or[g] | cell_pick[g * GROUP + k];
        end
      end
    end
  end

  // Second tree level: OR across the registered groups
  always_comb begin
    removed_or = '0;
    for (int g = 0; g < GROUPS; g++) begin
      removed_or = removed_or | group_reg[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end
      if (a_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign a_count_ext = OUT_W'(a_count);

  always_ff @(posedge clk) begin
    if (accept) begin
      a_status <= st;
      a_del    <= cmd.del;
      a_count  <= count_next;
      for (int g = 0; g < GROUPS; g++) begin
        group_reg[g] <= group_or[g];
      end
    end
    if (a_move) begin
      status        <= a_status;
      removed_value <= a_del ? removed_or : '0;
      count_now     <= a_count_ext[ili_pkg::COUNT_W-1:0];
      is_empty      <= (a_count == '0);
      is_full       <= (a_count == CNT_W'(LIST_CAPACITY));
    end
  end

endmodule
